>>> src/rast_pkg.sv
package rast_pkg;

  localparam int unsigned LEAVES_DEF = 256;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SUM_W      = 64;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_ADD   = 2'd1,
    OP_SUM   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  // one step of the shared unit: whole block or single element
  typedef struct packed {
    op_e  op;
    logic full;
  } step_t;

endpackage

>>> src/rast_alu.sv
module rast_alu #(
  parameter int unsigned LOG_B = 4
) (
  input  rast_pkg::step_t            ctl_i,
  input  logic [rast_pkg::SUM_W-1:0] elem_i,
  input  logic [rast_pkg::SUM_W-1:0] lazy_i,
  input  logic [rast_pkg::SUM_W-1:0] bsum_i,
  input  logic [rast_pkg::SUM_W-1:0] val_i,
  input  logic [rast_pkg::SUM_W-1:0] acc_i,
  output logic [rast_pkg::SUM_W-1:0] elem_o,
  output logic [rast_pkg::SUM_W-1:0] lazy_o,
  output logic [rast_pkg::SUM_W-1:0] bsum_o,
  output logic [rast_pkg::SUM_W-1:0] acc_o
);
  import rast_pkg::*;

  logic [SUM_W-1:0] raw_new;

  // stored element is the true value less the block's pending add
  assign raw_new = val_i - lazy_i;

  always_comb begin
    elem_o = elem_i;
    lazy_o = lazy_i;
    bsum_o = bsum_i;
    acc_o  = acc_i;
    case (ctl_i.op)
      OP_WRITE: begin
        elem_o = raw_new;
        bsum_o = bsum_i + raw_new - elem_i;
      end
      OP_ADD: begin
        if (ctl_i.full) begin
          lazy_o = lazy_i + val_i;
          bsum_o = bsum_i + (val_i << LOG_B);
        end else begin
          elem_o = elem_i + val_i;
          bsum_o = bsum_i + val_i;
        end
      end
      OP_SUM: begin
        if (ctl_i.full) begin
          acc_o = acc_i + bsum_i;
        end else begin
          acc_o = acc_i + elem_i + lazy_i;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/range_add_range_sum_tree.sv
// Walk: a range add or query takes one step per partial-block element plus one per
//   whole block in range (at most 2*(B-1) + LEAVES/B steps, 46 at 256).
// Throughput: one item at a time; the next is taken once the last is done and,
//   for a query, its result has been taken. Set by the single update unit.
// Reset: async active low; block sums and adds clear at once, then the element
//   memory is swept to zero, address by address, with the input not ready.
module range_add_range_sum_tree #(
  parameter int unsigned LEAVES = rast_pkg::LEAVES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // range_first[7:0], range_last[15:8], value[47:16]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // range_sum[63:0]
);
  import rast_pkg::*;

  // Elements live in a memory, split into blocks of B; each block keeps its
  // sum and a pending add in flops. Element true value = stored + block add.
  localparam int unsigned LOG_L = $clog2(LEAVES);
  localparam int unsigned IW    = LOG_L;
  localparam int unsigned CW    = LOG_L + 1;
  localparam int unsigned EW    = (CW > IDX_W + 1) ? CW : IDX_W + 1;
  localparam int unsigned LOG_B = LOG_L / 2;
  localparam int unsigned BLK   = 1 << LOG_B;
  localparam int unsigned NB    = LEAVES >> LOG_B;
  localparam int unsigned BW    = IW - LOG_B;

  state_e state_q, state_d;

  logic [IDX_W-1:0] in_first, in_last;
  logic [VAL_W-1:0] in_val;
  op_e              in_op;
  logic [EW-1:0]    first_w, last_w, last_sat;
  logic             in_empty, in_fire;

  op_e              op_q;
  logic [EW-1:0]    idx_q, last_q;
  logic [SUM_W-1:0] val_q, acc_q;
  logic [IW-1:0]    clr_q;

  // stage 2 of the walk: memory data has arrived, shared unit works
  logic             s2_valid_q;
  step_t            s2_ctl_q;
  logic [IW-1:0]    s2_idx_q;
  logic [BW-1:0]    s2_blk;

  logic             issue, full_step;
  logic [SUM_W-1:0] mem [LEAVES];
  logic [SUM_W-1:0] rd_q;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [SUM_W-1:0] mem_wdata;

  logic [SUM_W-1:0] lazy_q [NB];
  logic [SUM_W-1:0] bsum_q [NB];
  logic [SUM_W-1:0] elem_n, lazy_n, bsum_n, acc_n;

  // ---- input unpacking and range clean-up ----
  assign in_first = s_axis_tdata[7:0];
  assign in_last  = s_axis_tdata[15:8];
  assign in_val   = s_axis_tdata[47:16];
  assign in_op    = op_e'(s_axis_tuser);
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  assign first_w  = EW'(in_first);
  assign last_w   = EW'(in_last);
  // last past the store saturates; first past it empties the range
  assign last_sat = (last_w >= EW'(LEAVES)) ? EW'(LEAVES - 1) : last_w;
  assign in_empty = (first_w >= EW'(LEAVES)) || (first_w > last_sat);

  // ---- walk control ----
  assign issue     = (state_q == ST_RUN) && (idx_q <= last_q);
  // whole block when aligned and fully inside; writes always go per element
  assign full_step = (op_q != OP_WRITE) && ((idx_q & EW'(BLK - 1)) == '0)
                     && ((idx_q + EW'(BLK - 1)) <= last_q);
  assign s2_blk    = s2_idx_q[IW-1:LOG_B];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == IW'(LEAVES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_WRITE: state_d = (first_w < EW'(LEAVES)) ? ST_RUN : ST_IDLE;
            OP_ADD:   state_d = in_empty ? ST_IDLE : ST_RUN;
            OP_SUM:   state_d = in_empty ? ST_OUT : ST_RUN;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (!issue && !s2_valid_q) begin
          state_d = (op_q == OP_SUM) ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_OUT);
    m_axis_tdata  = acc_q;
    mem_we        = 1'b0;
    mem_waddr     = s2_idx_q;
    mem_wdata     = elem_n;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (s2_valid_q && !s2_ctl_q.full && (s2_ctl_q.op != OP_SUM)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s2_valid_q <= issue;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // ---- item registers and walk pointer ----
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_op;
      val_q <= SUM_W'(signed'(in_val));
      acc_q <= '0;
      idx_q <= first_w;
      last_q <= (in_op == OP_WRITE) ? first_w : last_sat;
    end else begin
      if (issue) begin
        idx_q <= full_step ? idx_q + EW'(BLK) : idx_q + 1'b1;
      end
      if (s2_valid_q) begin
        acc_q <= acc_n;
      end
    end
    s2_ctl_q <= '{op: op_q, full: full_step};
    s2_idx_q <= idx_q[IW-1:0];
  end

  // ---- element memory: one write, one registered read ----
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[idx_q[IW-1:0]];
  end

  // ---- block sums and pending adds ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NB; b++) begin
        lazy_q[b] <= '0;
        bsum_q[b] <= '0;
      end
    end else if (s2_valid_q) begin
      lazy_q[s2_blk] <= lazy_n;
      bsum_q[s2_blk] <= bsum_n;
    end
  end

  rast_alu #(
    .LOG_B (LOG_B)
  ) u_alu (
    .ctl_i  (s2_ctl_q),
    .elem_i (rd_q),
    .lazy_i (lazy_q[s2_blk]),
    .bsum_i (bsum_q[s2_blk]),
    .val_i  (val_q),
    .acc_i  (acc_q),
    .elem_o (elem_n),
    .lazy_o (lazy_n),
    .bsum_o (bsum_n),
    .acc_o  (acc_n)
  );

endmodule

>>> src/rast_chk.sv
module rast_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  import rast_pkg::*;

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == OP_SUM) && (s_axis_tdata[7:0] > s_axis_tdata[15:8])
    |=> m_axis_tvalid && (m_axis_tdata == '0))
    else $error("empty range query must give zero at once");

  a_nop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == OP_NONE) |=> s_axis_tready && !m_axis_tvalid)
    else $error("unused opcode must leave the block idle");

endmodule

bind range_add_range_sum_tree rast_chk u_rast_chk (.*);
